### hw/rtl/rotary_indexer_stepper_unit_assert.svh
// Assertion macros for the rotary indexer stepper unit.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ROTARY_INDEXER_STEPPER_UNIT_ASSERT_SVH
`define ROTARY_INDEXER_STEPPER_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define RIS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RIS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ris_pkg.sv
// Shared types and constants for the rotary indexer stepper unit.
// No dependencies.
package ris_pkg;

    localparam int SLOT_COUNT = 8;   // power of two: slot arithmetic wraps naturally
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CMD_W      = 2;
    localparam int PHASE_W    = 4;
    localparam int MODE_W     = 2;
    localparam int DIV_W      = 8;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GOTO = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SLOT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HOME = 2'd3;

    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd8;
    localparam logic [PHASE_W-1:0] PHASE_OFF   = 4'd9;

    localparam logic [DIV_W-1:0] DIVIDE_RESET = 8'd12;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] target_slot;
    } item_t;

    // packed phase lowest, so the struct drops straight into tdata
    typedef struct packed {
        logic              arrived;
        logic [SLOT_W-1:0] position;
        logic [MODE_W-1:0] direction;
        logic [PHASE_W-1:0] phase;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

### hw/rtl/ris_core.sv
// Carousel state and next-state logic: position, target, motion, phase, tick divider.
// Depends on ris_pkg and rotary_indexer_stepper_unit_assert.svh.
`include "rotary_indexer_stepper_unit_assert.svh"

module ris_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_en,
    input  ris_pkg::item_t          item,
    input  logic                    cfg_we,
    input  logic [ris_pkg::DIV_W-1:0] cfg_divide,
    output ris_pkg::result_t        result
);

    logic [ris_pkg::SLOT_W-1:0]  position_reg, position_next;
    logic [ris_pkg::SLOT_W-1:0]  target_reg, target_next;
    logic [ris_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [ris_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [ris_pkg::DIV_W-1:0]   tick_reg, tick_next;
    logic [ris_pkg::DIV_W-1:0]   divide_reg;

    logic [ris_pkg::DIV_W-1:0]   tick_inc;
    logic [ris_pkg::SLOT_W-1:0]  slot_gap;
    logic [ris_pkg::SLOT_W-1:0]  position_moved;
    logic [ris_pkg::PHASE_W-1:0] phase_stepped;

    // one half-step of the phase index; stopped forces coils off
    always_comb
    begin
        phase_stepped = phase_reg;
        if (mode_reg == ris_pkg::MODE_FWD)
        begin
            if (phase_reg >= ris_pkg::PHASE_LAST)
                phase_stepped = ris_pkg::PHASE_FIRST;
            else
                phase_stepped = phase_reg + 4'd1;
        end
        else if (mode_reg == ris_pkg::MODE_REV)
        begin
            if (phase_reg <= ris_pkg::PHASE_FIRST || phase_reg > ris_pkg::PHASE_OFF)
                phase_stepped = ris_pkg::PHASE_LAST;
            else
                phase_stepped = phase_reg - 4'd1;
        end
        else
            phase_stepped = ris_pkg::PHASE_OFF;
    end

    assign tick_inc = tick_reg + 8'd1;
    assign slot_gap = item.target_slot - position_reg;   // wraps mod SLOT_COUNT

    always_comb
    begin
        position_moved = position_reg;
        if (mode_reg == ris_pkg::MODE_FWD)
            position_moved = position_reg + 1'b1;
        else if (mode_reg == ris_pkg::MODE_REV)
            position_moved = position_reg - 1'b1;
    end

    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        unique case (item.cmd)
            ris_pkg::CMD_TICK:
            begin
                if (tick_inc >= divide_reg)
                begin
                    phase_next = phase_stepped;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_inc;
            end
            ris_pkg::CMD_GOTO:
            begin
                target_next = item.target_slot;
                if (slot_gap == '0)
                    mode_next = ris_pkg::MODE_STOP;
                else if ({1'b0, slot_gap} <= (ris_pkg::SLOT_W+1)'(ris_pkg::SLOT_COUNT / 2))
                    mode_next = ris_pkg::MODE_FWD;
                else
                    mode_next = ris_pkg::MODE_REV;
            end
            ris_pkg::CMD_SLOT:
            begin
                position_next = position_moved;
                if (position_moved == target_reg)
                    mode_next = ris_pkg::MODE_STOP;
            end
            ris_pkg::CMD_HOME:
            begin
                mode_next     = ris_pkg::MODE_STOP;
                position_next = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            target_reg   <= '0;
            mode_reg     <= ris_pkg::MODE_STOP;
            phase_reg    <= ris_pkg::PHASE_OFF;
            tick_reg     <= '0;
            divide_reg   <= ris_pkg::DIVIDE_RESET;
        end
        else
        begin
            if (step_en)
            begin
                position_reg <= position_next;
                target_reg   <= target_next;
                mode_reg     <= mode_next;
                phase_reg    <= phase_next;
                tick_reg     <= tick_next;
            end
            if (cfg_we)
                divide_reg <= cfg_divide;
        end
    end

    assign result.phase     = (phase_next >= ris_pkg::PHASE_OFF) ? '0 : phase_next;
    assign result.direction = mode_next;
    assign result.position  = position_next;
    assign result.arrived   = (mode_next == ris_pkg::MODE_STOP);

    `RIS_ASSERT_ALWAYS(a_phase_range,
        phase_reg >= ris_pkg::PHASE_FIRST && phase_reg <= ris_pkg::PHASE_OFF,
        "phase index left 1..9")
    `RIS_ASSERT_NEXT(a_home_zeroes,
        step_en && item.cmd == ris_pkg::CMD_HOME,
        position_reg == '0 && mode_reg == ris_pkg::MODE_STOP,
        "home edge did not stop and zero position")
    `RIS_ASSERT_NEXT(a_tick_bounded,
        step_en && item.cmd == ris_pkg::CMD_TICK,
        tick_reg < divide_reg || divide_reg == '0 || $past(cfg_we),
        "tick count not cleared at divide")

endmodule

### hw/rtl/rotary_indexer_stepper_unit.sv
// Top level of the rotary indexer stepper unit: stream ports, input and result registers.
// Depends on ris_pkg and ris_core.

// Carousel indexer for an 8-slot stepper, one result transaction per input
// transaction. Each item is registered on input, processed combinationally
// against the carousel state and registered on output, so one item per clock
// is sustained; m_tvalid comes from the output register, which loads from the
// input register. Throughput drops only when m_tready is held low. s_tuser
// carries the command (0 tick, 1 goto, 2 slot edge, 3 home edge), s_tdata the
// target slot. tick_divide is written on the cfg channel (always ready) and
// should only be changed while idle.
module rotary_indexer_stepper_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [2:0] target_slot
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [3:0] phase, [5:4] direction, [8:6] position, [9] arrived
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data    // [7:0] tick_divide
);

    logic             in_valid_reg;
    ris_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    ris_pkg::result_t out_result_reg;
    ris_pkg::result_t core_result;
    logic             out_free;
    logic             step_en;

    assign out_free  = !out_valid_reg || m_tready;
    assign step_en   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.cmd         <= s_tuser;
            in_item_reg.target_slot <= s_tdata[ris_pkg::SLOT_W-1:0];
        end
        if (step_en)
            out_result_reg <= core_result;
    end

    ris_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .item       (in_item_reg),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_divide (cfg_data),
        .result     (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(16 - ris_pkg::RESULT_W)'(0), out_result_reg};

endmodule
